/* rtl/aes_ctr_pkg.sv */
// Package for the AES-128 counter-mode unit: payload structs, register
// indexes, state enum and the S-box / round helper functions. No dependencies.
`default_nettype none
package aes_ctr_pkg;

    typedef struct packed {
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  byte_count;
        logic        first_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic [4:0]  result_count;
    } t_out_item;

    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_LOW       = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_NONCE_HIGH    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_NONCE_LOW     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_COUNTER_START = 3'd4;

    localparam int unsigned NumRounds = 10;
    localparam int unsigned RoundW    = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_INIT,
        ST_ROUND,
        ST_DONE
    } t_state;

    // Control from the sequencer to the round datapath
    typedef struct packed {
        logic              load;
        logic              step;
        logic              last;
        logic              expand;
        logic [RoundW-1:0] round;
    } t_rnd_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        begin
            case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] rcon(input logic [RoundW-1:0] n);
        logic [7:0] r;
        begin
            case (n)
            4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
            4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
            4'd9: r = 8'h1b; 4'd10: r = 8'h36;
            default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

/* rtl/aes_ctr_ram.sv */
// Generic RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module aes_ctr_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 22
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/aes_ctr_round.sv */
// AES-128 round datapath: one round per step, round keys held in two RAMs
// (high and low halves). Depends on aes_ctr_pkg and aes_ctr_ram.
`default_nettype none
module aes_ctr_round (
    input  wire                   i_clk,
    input  aes_ctr_pkg::t_rnd_ctl i_ctl,
    input  wire [127:0]           i_key,
    input  wire [127:0]           i_block,
    output logic [127:0]          o_state
);
    logic [127:0] r_state;
    logic [127:0] r_kexp;
    logic [127:0] n_kexp;
    logic [127:0] rk;
    logic [63:0]  rk_hi;
    logic [63:0]  rk_lo;
    logic [127:0] sr;
    logic [127:0] mc;
    logic [127:0] nxt;
    logic [31:0]  t;
    logic [3:0]   kaddr;

    // Key schedule: r_kexp holds round key (round-1) while writing round.
    always_comb begin
        t = {aes_ctr_pkg::sbox(r_kexp[23:16]), aes_ctr_pkg::sbox(r_kexp[15:8]),
             aes_ctr_pkg::sbox(r_kexp[7:0]), aes_ctr_pkg::sbox(r_kexp[31:24])}
            ^ {aes_ctr_pkg::rcon(i_ctl.round), 24'h0};
        n_kexp[127:96] = r_kexp[127:96] ^ t;
        n_kexp[95:64]  = r_kexp[95:64] ^ n_kexp[127:96];
        n_kexp[63:32]  = r_kexp[63:32] ^ n_kexp[95:64];
        n_kexp[31:0]   = r_kexp[31:0] ^ n_kexp[63:32];
    end

    logic [127:0] wkey;
    assign wkey = (i_ctl.round == '0) ? i_key : n_kexp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.expand) begin
            r_kexp <= wkey;
        end
    end

    // Read address leads the step that uses its key: the sequencer gives it.
    assign kaddr = i_ctl.round;

    aes_ctr_ram #(.WIDTH(64), .DEPTH(11)) u_rk_hi (
        .i_clk(i_clk), .i_we(i_ctl.expand), .i_waddr(kaddr), .i_wdata(wkey[127:64]),
        .i_raddr(kaddr), .o_rdata(rk_hi)
    );
    aes_ctr_ram #(.WIDTH(64), .DEPTH(11)) u_rk_lo (
        .i_clk(i_clk), .i_we(i_ctl.expand), .i_waddr(kaddr), .i_wdata(wkey[63:0]),
        .i_raddr(kaddr), .o_rdata(rk_lo)
    );
    assign rk = {rk_hi, rk_lo};

    // SubBytes, ShiftRows, MixColumns, key add; byte b at [127-8b -: 8]
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                sr[127 - 8*(4*c + row) -: 8] =
                    aes_ctr_pkg::sbox(r_state[127 - 8*(4*((c + row) % 4) + row) -: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sr[127 - 32*c -: 8];
            a1 = sr[119 - 32*c -: 8];
            a2 = sr[111 - 32*c -: 8];
            a3 = sr[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[127 - 32*c -: 8] = a0 ^ al ^ aes_ctr_pkg::xtime(a0 ^ a1);
            mc[119 - 32*c -: 8] = a1 ^ al ^ aes_ctr_pkg::xtime(a1 ^ a2);
            mc[111 - 32*c -: 8] = a2 ^ al ^ aes_ctr_pkg::xtime(a2 ^ a3);
            mc[103 - 32*c -: 8] = a3 ^ al ^ aes_ctr_pkg::xtime(a3 ^ a0);
        end
        // Final round skips MixColumns
        nxt = (i_ctl.last ? sr : mc) ^ rk;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_state <= i_block ^ rk;
        end else if (i_ctl.step) begin
            r_state <= nxt;
        end
    end

    assign o_state = r_state;
endmodule
`default_nettype wire

/* rtl/aes128_ctr_stream_cipher_unit.sv */
// Top level of the AES-128 counter-mode stream cipher.
// Depends on aes_ctr_pkg and aes_ctr_round (which uses aes_ctr_ram).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid/o_in_ready   | i_in (t_in_item)
//  out     | out       | o_out_valid/i_out_ready | o_out (t_out_item)
//
// A block goes from transfer to result valid through key read, initial key
// addition, ten rounds and mask; a first block first adds key expansion of
// round keys 0 to 10, one round key per cycle, written into the round key RAMs.
// All rounds share one round unit, which reads keys through registered RAMs.
// Reset is synchronous, active low; it clears the sequencer, the counter,
// the configuration registers and output valid. A stalled result holds in the
// output register; a new input transfer is taken once the result is gone.
`default_nettype none
module aes128_ctr_stream_cipher_unit (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [2:0]              i_cfg_index,
    input  wire [63:0]             i_cfg_data,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  aes_ctr_pkg::t_in_item  i_in,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output aes_ctr_pkg::t_out_item o_out
);
    aes_ctr_pkg::t_state r_state, n_state;
    logic [3:0]   r_round, n_round;
    logic [63:0]  r_key_high, r_key_low, r_nonce_low;
    logic [31:0]  r_nonce_high, r_counter_start, r_counter;
    logic [127:0] r_data;
    logic [4:0]   r_count;
    logic         r_out_valid;
    logic         r_capture;
    aes_ctr_pkg::t_out_item r_out;
    aes_ctr_pkg::t_rnd_ctl  ctl;
    logic [127:0] ks;
    logic [127:0] mask;
    logic         in_xfer;
    logic [4:0]   cnt;

    assign o_cfg_ready = 1'b1;
    // Hold off input outside IDLE and while a result is pending capture or waiting downstream
    assign o_in_ready  = (r_state == aes_ctr_pkg::ST_IDLE) && !r_out_valid && !r_capture;
    assign in_xfer     = i_in_valid && o_in_ready;

    // Clamp the byte count into 1..16
    always_comb begin
        if (i_in.byte_count == 5'd0) begin
            cnt = 5'd1;
        end else if (i_in.byte_count > 5'd16) begin
            cnt = 5'd16;
        end else begin
            cnt = i_in.byte_count;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0; r_key_low <= '0; r_nonce_high <= '0;
            r_nonce_low <= '0; r_counter_start <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
            aes_ctr_pkg::CFG_KEY_HIGH:      r_key_high <= i_cfg_data;
            aes_ctr_pkg::CFG_KEY_LOW:       r_key_low <= i_cfg_data;
            aes_ctr_pkg::CFG_NONCE_HIGH:    r_nonce_high <= i_cfg_data[31:0];
            aes_ctr_pkg::CFG_NONCE_LOW:     r_nonce_low <= i_cfg_data;
            aes_ctr_pkg::CFG_COUNTER_START: r_counter_start <= i_cfg_data[31:0];
            default: ;
            endcase
        end
    end

    // Next state: EXPAND walks rounds 0..10; INIT reads key 0,
    // ROUND applies the key addition, then rounds 1..9; DONE runs round 10.
    always_comb begin
        n_state = r_state;
        n_round = r_round;
        unique case (r_state)
        aes_ctr_pkg::ST_IDLE: begin
            n_round = '0;
            if (in_xfer) begin
                n_state = i_in.first_block ? aes_ctr_pkg::ST_EXPAND : aes_ctr_pkg::ST_INIT;
            end
        end
        aes_ctr_pkg::ST_EXPAND: begin
            if (r_round == 4'(aes_ctr_pkg::NumRounds)) begin
                n_round = '0;
                n_state = aes_ctr_pkg::ST_INIT;
            end else begin
                n_round = r_round + 4'd1;
            end
        end
        aes_ctr_pkg::ST_INIT: begin
            n_round = 4'd1;
            n_state = aes_ctr_pkg::ST_ROUND;
        end
        aes_ctr_pkg::ST_ROUND: begin
            if (r_round == 4'(aes_ctr_pkg::NumRounds)) begin
                n_state = aes_ctr_pkg::ST_DONE;
            end else begin
                n_round = r_round + 4'd1;
            end
        end
        aes_ctr_pkg::ST_DONE: begin
            n_state = aes_ctr_pkg::ST_IDLE;
        end
        default: n_state = aes_ctr_pkg::ST_IDLE;
        endcase
    end

    // Outputs toward the round unit. The RAM read is registered, so the
    // address runs ahead of the step that uses its key: in ROUND at count r
    // the address is r, and the key arrives for the next step.
    always_comb begin
        ctl = '0;
        unique case (r_state)
        aes_ctr_pkg::ST_EXPAND: begin
            ctl.expand = 1'b1;
            ctl.round  = r_round;
        end
        aes_ctr_pkg::ST_INIT: begin
            ctl.round = 4'd0;
        end
        aes_ctr_pkg::ST_ROUND: begin
            ctl.load  = (r_round == 4'd1);
            ctl.step  = (r_round != 4'd1);
            ctl.round = r_round;
        end
        aes_ctr_pkg::ST_DONE: begin
            ctl.step  = 1'b1;
            ctl.last  = 1'b1;
            ctl.round = 4'(aes_ctr_pkg::NumRounds);
        end
        default: ;
        endcase
    end

    aes_ctr_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_key   ({r_key_high, r_key_low}),
        .i_block ({r_nonce_high, r_nonce_low, r_counter}),
        .o_state (ks)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_ctr_pkg::ST_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    // Hold input payload; load counter on first block, advance per block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (in_xfer && i_in.first_block) begin
            r_counter <= r_counter_start;
        end else if (r_state == aes_ctr_pkg::ST_DONE) begin
            r_counter <= r_counter + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_data  <= {i_in.data_high, i_in.data_low};
            r_count <= cnt;
        end
    end

    always_comb begin
        for (int b = 0; b < 16; b++) begin
            mask[127 - 8*b -: 8] = (5'(b) < r_count) ? 8'hff : 8'h00;
        end
    end

    // Result register: ks is final in the cycle after DONE, so capture in IDLE
    // following DONE. Use a one-cycle flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_capture <= (r_state == aes_ctr_pkg::ST_DONE);
            if (r_capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_capture) begin
            r_out.result_high  <= (r_data[127:64] ^ ks[127:64]) & mask[127:64];
            r_out.result_low   <= (r_data[63:0] ^ ks[63:0]) & mask[63:0];
            r_out.result_count <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Block input while the capture cycle is pending.
    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_capture |-> !in_xfer;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy)
        else $error("input transfer during capture");

    property p_done_capture;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == aes_ctr_pkg::ST_DONE) |=> r_capture;
    endproperty
    a_done_capture: assert property (p_done_capture)
        else $error("result not captured after final round");

    property p_round_bound;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_round <= 4'(aes_ctr_pkg::NumRounds);
    endproperty
    a_round_bound: assert property (p_round_bound)
        else $error("round counter out of range");
endmodule
`default_nettype wire
